FILE: rtl/core/mrrf_pkg.sv
// ----------------------------------------------------------------------------
// mrrf_pkg
// types, constants and the crc byte update for the read request framer
// ----------------------------------------------------------------------------
`default_nettype none

package mrrf_pkg;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_INPUT_REGS   = 8'h04;
  localparam logic [7:0]  FUNC_HOLDING_REGS = 8'h03;
  localparam logic [3:0]  INPUT_CLASS_DIGIT = 4'd3;
  localparam int          FRAME_LEN         = 8;
  localparam int          IDX_W             = $clog2(FRAME_LEN);

  // frame byte positions, transmit order
  localparam logic [IDX_W-1:0] POS_ID       = 3'd0;
  localparam logic [IDX_W-1:0] POS_FUNC     = 3'd1;
  localparam logic [IDX_W-1:0] POS_ADDR_HI  = 3'd2;
  localparam logic [IDX_W-1:0] POS_ADDR_LO  = 3'd3;
  localparam logic [IDX_W-1:0] POS_COUNT_HI = 3'd4;
  localparam logic [IDX_W-1:0] POS_COUNT_LO = 3'd5;
  localparam logic [IDX_W-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [IDX_W-1:0] POS_CRC_HI   = 3'd7;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [3:0]  leading_digit;
    logic [16:0] register_number;
    logic [15:0] register_count;
  } request_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_t;

  // crc-16 modbus update over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/modbus_read_request_framer_unit.sv
// ----------------------------------------------------------------------------
// modbus_read_request_framer_unit
// turns one read request into the eight byte rtu frame with its crc
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   word
//  request   in         request_valid/request_stall request_t (one read request)
//  frame     out        frame_valid/frame_stall     frame_t (one frame byte)
//
//  the eight frame bytes share the one-word output register, so one byte leaves
//  per cycle unless frame_stall holds the output, and the crc follows the header bytes out
//  the next request is taken in the cycle that loads the crc high byte, so frames
//  follow each other with no gap
//  rst (synchronous) empties the frame buffer and the output register
//  frame_stall holds a valid output word and freezes the byte sequencer
//
`default_nettype none

module modbus_read_request_framer_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 request_valid,
  output logic                request_stall,
  input  wire mrrf_pkg::request_t request,
  output logic                frame_valid,
  input  wire                 frame_stall,
  output mrrf_pkg::frame_t    frame
);
  import mrrf_pkg::*;

  // frame buffer: the six header bytes of the request being sent
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic [7:0]       dev_id;
  logic [7:0]       func_code;
  logic [15:0]      start_addr;
  logic [15:0]      reg_count;

  logic             load;
  logic             accept;
  logic [7:0]       cur_byte;
  logic [16:0]      start_wide;

  // output register may take a new word when empty or being drained
  assign load   = busy && (!frame_valid || !frame_stall);
  // free buffer, or the crc high byte is going out this cycle
  assign request_stall = busy && !(load && idx == POS_CRC_HI);
  assign accept = request_valid && !request_stall;

  assign start_wide = request.register_number - 17'd1;

  // byte at the current position
  always_comb begin
    unique case (idx)
      POS_ID:       cur_byte = dev_id;
      POS_FUNC:     cur_byte = func_code;
      POS_ADDR_HI:  cur_byte = start_addr[15:8];
      POS_ADDR_LO:  cur_byte = start_addr[7:0];
      POS_COUNT_HI: cur_byte = reg_count[15:8];
      POS_COUNT_LO: cur_byte = reg_count[7:0];
      POS_CRC_LO:   cur_byte = crc[7:0];
      POS_CRC_HI:   cur_byte = crc[15:8];
      default:      cur_byte = 8'h00;
    endcase
  end

  // sequencer and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (load) begin
        idx <= idx + 1'b1;
        if (idx == POS_CRC_HI) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dev_id     <= request.device_id;
      func_code  <= (request.leading_digit == INPUT_CLASS_DIGIT) ? FUNC_INPUT_REGS
                                                                  : FUNC_HOLDING_REGS;
      start_addr <= start_wide[15:0];
      reg_count  <= request.register_count;
      crc        <= CRC_INIT;
    end else if (load && idx < POS_CRC_LO) begin
      // header bytes feed the crc as they go out
      crc <= crc_byte(crc, cur_byte);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || !frame_stall) begin
      frame_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame.frame_byte <= cur_byte;
      frame.last_byte  <= (idx == POS_CRC_HI);
    end
  end

  // checks on the sequencer
  a_idle_idx_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> idx == '0)
    else $error("sequencer position not cleared while idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && idx == '0)
    else $error("accepted request did not start at the id byte");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    busy && frame_valid && frame_stall |=> $stable(idx) && $stable(crc))
    else $error("sequencer moved while output stalled");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame.last_byte |-> idx == '0)
    else $error("last byte out but sequencer not wrapped");

endmodule

`default_nettype wire
